### design/stt_pkg.sv
// Shared types, character codes and helpers for the source text tokenizer.
// No dependencies; imported by every module of the block.
package stt_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int POS_OUT_W         = 16;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_SQ    = 3'd2,
        MODE_ANGLE = 3'd3,
        MODE_DQ    = 3'd4
    } t_mode;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_WORD  = 3'd0;
    localparam t_kind KIND_SQ    = 3'd1;
    localparam t_kind KIND_ANGLE = 3'd2;
    localparam t_kind KIND_DQ    = 3'd3;
    localparam t_kind KIND_PUNCT = 3'd4;

    typedef struct packed {
        logic [7:0]           tok_byte;
        t_kind                kind;
        logic                 first;
        logic                 done;
        logic [POS_OUT_W-1:0] line_num;
        logic [POS_OUT_W-1:0] col_num;
        logic                 run_last;
    } t_result;

    // Results of one input byte: up to two, in order r0 then r1.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_step;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic t_result mk_result(input logic [7:0] b, input t_kind k,
                                          input logic f, input logic d,
                                          input logic [POS_OUT_W-1:0] ln,
                                          input logic [POS_OUT_W-1:0] cl);
        t_result r;
        r.tok_byte = b;
        r.kind     = k;
        r.first    = f;
        r.done     = d;
        r.line_num = ln;
        r.col_num  = cl;
        r.run_last = 1'b0;
        return r;
    endfunction

    function automatic t_step add_result(input t_step s, input t_result r);
        t_step o;
        o = s;
        if (s.count == 2'd0) begin
            o.r0 = r;
        end else begin
            o.r1 = r;
        end
        o.count = s.count + 2'd1;
        return o;
    endfunction

endpackage

### design/stt_scan.sv
// Scanner state and the combinational step logic that turns a byte into results.
// Depends on stt_pkg.
module stt_scan import stt_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output t_step      o_step
);

    localparam logic [POSITION_BITS-1:0] LINE_INIT = POSITION_BITS'(1);

    t_mode                    r_mode, n_mode;
    logic                     r_ab, n_ab;
    logic [7:0]               r_hb, n_hb;
    logic                     r_hf, n_hf;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;

    function automatic logic [POSITION_BITS-1:0] sat_inc(
        input logic [POSITION_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always_comb begin
        t_step      st;
        logic       do_idle;
        logic [7:0] q;
        t_kind      k;
        st      = '0;
        do_idle = 1'b0;
        n_mode  = r_mode;
        n_ab    = r_ab;
        n_hb    = r_hb;
        n_hf    = r_hf;
        n_line  = r_line;
        n_col   = r_col;
        q       = (r_mode == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
        k       = (r_mode == MODE_SQ) ? KIND_SQ : KIND_DQ;

        unique case (r_mode)
            MODE_WORD: begin
                // held byte goes out once the next byte shows whether it ends the word
                if (is_alnum(i_byte)) begin
                    st = add_result(st, mk_result(r_hb, KIND_WORD, r_hf, 1'b0,
                                    POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
                    n_hb  = i_byte;
                    n_hf  = 1'b0;
                    n_col = sat_inc(n_col);
                end else begin
                    st = add_result(st, mk_result(r_hb, KIND_WORD, r_hf, 1'b1,
                                    POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
                    n_hf    = 1'b0;
                    n_mode  = MODE_IDLE;
                    do_idle = 1'b1;
                end
            end
            MODE_SQ, MODE_DQ: begin
                n_col = sat_inc(n_col);
                if (r_ab && i_byte == q) begin
                    n_ab = 1'b0;
                    st = add_result(st, mk_result(i_byte, k, 1'b0, i_eot,
                                    POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
                end else if (i_byte == q) begin
                    n_ab   = 1'b0;
                    n_mode = MODE_IDLE;
                    st = add_result(st, mk_result(i_byte, k, 1'b0, 1'b1,
                                    POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
                end else begin
                    n_ab = (i_byte == CH_BSLASH);
                    st = add_result(st, mk_result(i_byte, k, 1'b0, i_eot,
                                    POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
                end
            end
            MODE_ANGLE: begin
                n_col = sat_inc(n_col);
                if (i_byte == CH_GT) begin
                    n_mode = MODE_IDLE;
                    st = add_result(st, mk_result(i_byte, KIND_ANGLE, 1'b0, 1'b1,
                                    POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
                end else begin
                    st = add_result(st, mk_result(i_byte, KIND_ANGLE, 1'b0, i_eot,
                                    POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
                end
            end
            default: begin
                n_mode  = MODE_IDLE;
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            priority if (is_alnum(i_byte)) begin
                n_hb   = i_byte;
                n_hf   = 1'b1;
                n_mode = MODE_WORD;
                n_col  = sat_inc(n_col);
            end else if (i_byte == CH_SQUOTE || i_byte == CH_LT || i_byte == CH_DQUOTE) begin
                n_col = sat_inc(n_col);
                n_ab  = 1'b0;
                if (i_byte == CH_SQUOTE) begin
                    n_mode = MODE_SQ;
                    k      = KIND_SQ;
                end else if (i_byte == CH_LT) begin
                    n_mode = MODE_ANGLE;
                    k      = KIND_ANGLE;
                end else begin
                    n_mode = MODE_DQ;
                    k      = KIND_DQ;
                end
                st = add_result(st, mk_result(i_byte, k, 1'b1, i_eot,
                                POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
            end else if (i_byte == CH_SPACE || i_byte == CH_TAB) begin
                n_col = sat_inc(n_col);
            end else if (i_byte == CH_NL) begin
                n_line = sat_inc(n_line);
                n_col  = '0;
            end else begin
                n_col = sat_inc(n_col);
                st = add_result(st, mk_result(i_byte, KIND_PUNCT, 1'b1, 1'b1,
                                POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
            end
        end

        // end of text: flush a held word byte, then back to the reset state
        if (i_eot) begin
            if (n_mode == MODE_WORD) begin
                st = add_result(st, mk_result(n_hb, KIND_WORD, n_hf, 1'b1,
                                POS_OUT_W'(n_line), POS_OUT_W'(n_col)));
            end
            n_mode = MODE_IDLE;
            n_ab   = 1'b0;
            n_hb   = '0;
            n_hf   = 1'b0;
            n_line = LINE_INIT;
            n_col  = '0;
        end

        o_step = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_ab   <= 1'b0;
            r_hf   <= 1'b0;
            r_line <= LINE_INIT;
            r_col  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_ab   <= n_ab;
            r_hf   <= n_hf;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_hb <= n_hb;
        end
    end

endmodule

### design/stt_obuf.sv
// Two-slot result register: holds the results of one byte and hands them out
// one transfer per cycle while the receiver is ready. Depends on stt_pkg.
module stt_obuf import stt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_step   i_step,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic       w_fire;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_res      = r_slot0;
    assign w_fire     = o_valid && i_ready;
    // loading overwrites both slots, so the buffer has to drain this cycle
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && w_fire);

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_load) begin
            n_slot0          = i_step.r0;
            n_slot0.run_last = (i_step.count == 2'd1);
            n_slot1          = i_step.r1;
            n_slot1.run_last = 1'b1;
            n_cnt            = i_step.count;
        end else if (w_fire) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

### design/source_text_tokenizer_unit.sv
// Source text tokenizer, top level: input register, scanner and result buffer.
// Depends on stt_pkg, stt_scan and stt_obuf.
//
// Usage:
//   s_axis takes one text byte per transfer; tlast marks the last byte of a
//   text. m_axis gives token characters, one per transfer: tdata carries the
//   byte, line and column, tuser the token kind and first/done marks, tlast
//   the last result caused by one input byte.
//   A byte is scanned while it sits in the input register, and its results
//   load the result register at the edge on which it leaves, and the result
//   register offers them from there. A byte makes zero, one or two results;
//   the result register drains one per cycle while the receiver is ready, so the
//   block takes one byte per cycle while bytes make at most one result, and
//   waits for the second of two to leave. The width of the result channel sets that.
//   Words are held back one byte: their last character goes out with the
//   byte that ends the word, or at end of text.
//   Reset (synchronous, active low) empties both registers and returns the
//   scanner to line 1, column 0, outside any token. When the receiver stalls,
//   the result register holds, the input register fills, and s_axis_tready
//   drops until results drain.
module source_text_tokenizer_unit import stt_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] token_byte, [23:8] line_number,
                                        // [39:24] column_number
    output logic [4:0]  m_axis_tuser,   // [2:0] token_kind, [3] token_first,
                                        // [4] token_done
    output logic        m_axis_tlast    // run_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eot;
    logic       w_can_load;
    logic       w_proc;
    t_step      w_step;
    t_result    w_res;

    assign w_proc        = r_in_valid && w_can_load;
    assign s_axis_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eot  <= s_axis_tlast;
        end
    end

    stt_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_proc),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .o_step  (w_step)
    );

    stt_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_proc),
        .i_step     (w_step),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .o_res      (w_res),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {w_res.col_num, w_res.line_num, w_res.tok_byte};
    assign m_axis_tuser = {w_res.done, w_res.first, w_res.kind};
    assign m_axis_tlast = w_res.run_last;

`ifndef SYNTH
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |-> (w_step.count != 2'd3))
        else $error("scanner produced more than two results");

    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_step.count == 2'd2) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("first of two results missing or marked last");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_step.count == 2'd1) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("single result missing or not marked last");

    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_step.count == 2'd0) |=> !m_axis_tvalid)
        else $error("result shown for a byte that makes none");
`endif

endmodule
